// File: design/dcrp_pkg.sv
// ----------------------------------------------------------------------------
// dcrp_pkg
// Types, constants and helpers for the two-channel ROM PCM player.
// ----------------------------------------------------------------------------
`default_nettype none

package dcrp_pkg;

  localparam int unsigned ROM_DEPTH_DEF = 131072;
  localparam int unsigned LIM_W         = 26;
  localparam int unsigned STEP_W        = 13;
  localparam int unsigned PHASE_W       = 14;
  localparam int unsigned PADDR_W       = 18;
  localparam int unsigned START_W       = 17;
  localparam int unsigned SUM_W         = 17;

  localparam logic [STEP_W-1:0]  PHASE_TOP = 13'h1000;
  localparam logic [PHASE_W-1:0] PHASE_KEY = 14'h1000;
  localparam logic [PHASE_W-1:0] PHASE_DEC = 14'd32;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  localparam logic [7:0] OFF_KEY0  = 8'h05;
  localparam logic [7:0] OFF_KEY1  = 8'h0B;
  localparam logic [7:0] OFF_PORT  = 8'h0C;
  localparam logic [7:0] OFF_LOOP  = 8'h0D;
  localparam logic [7:0] OFF_VOL0L = 8'h10;
  localparam logic [7:0] OFF_VOL0R = 8'h11;
  localparam logic [7:0] OFF_VOL1L = 8'h12;
  localparam logic [7:0] OFF_VOL1R = 8'h13;
  localparam logic [7:0] OFF_BANK0 = 8'h14;
  localparam logic [7:0] OFF_BANK1 = 8'h15;

  localparam logic REG_ROM_SPAN = 1'b0;
  localparam logic REG_MUTE     = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  reg_offset;
    logic [7:0]  reg_data;
    logic [16:0] rom_address;
    logic [7:0]  rom_byte;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] left_sum;
    logic signed [15:0] right_sum;
    logic [7:0]         read_data;
    logic               port_strobe;
    logic [7:0]         port_data;
  } res_t;

  function automatic logic [STEP_W-1:0] calc_step(input logic [7:0] lo, input logic [7:0] hi);
    logic [STEP_W-1:0] r;
    r = '0;
    unique case (hi[5:4])
      2'd1:    r = (13'd256 - {5'd0, lo}) << 4;
      2'd2:    r = (13'd16 - {9'd0, hi[3:0]}) << 8;
      default: r = {1'b0, hi[3:0], lo};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/dual_channel_rom_pcm_player.sv
// ----------------------------------------------------------------------------
// dual_channel_rom_pcm_player
// Two-channel PCM player mixing 7-bit samples read from a byte ROM.
// ----------------------------------------------------------------------------
// Register writes, reads and ROM loads return their result registered on the
// accepting edge.
// A tick reads the sample and each address step of every playing channel
// through the single read port of the sample ROM.
// One transaction is handled at a time.
// After reset the ROM is filled with 0xFF at every address; no transaction is
// accepted until then, configuration writes are.
`default_nettype none

module dual_channel_rom_pcm_player
  import dcrp_pkg::*;
#(
  parameter int unsigned ROM_DEPTH = ROM_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_t        cmd,
  output logic             res_valid,
  input  wire logic        res_stall,
  output res_t             res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(ROM_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(ROM_DEPTH - 1);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_CH   = 7'b0000100,
    S_SAMP = 7'b0001000,
    S_LOOP = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  logic [AW-1:0] clr_idx;

  logic [17:0] rom_span;
  logic [1:0]  mute_mask;

  logic [7:0]         raw_regs [16];
  logic [STEP_W-1:0]  step_value [2];
  logic [START_W-1:0] start_addr [2];
  logic [PADDR_W-1:0] play_addr [2];
  logic [PHASE_W-1:0] phase_count [2];
  logic [1:0]         playing;
  logic [7:0]         volume [4];
  logic [7:0]         bank_sel [2];
  logic [7:0]         loop_enable;

  logic                  ch;
  logic signed [SUM_W-1:0] lsum;
  logic signed [SUM_W-1:0] rsum;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MUTE) begin
      prdata = {30'd0, mute_mask};
    end else begin
      prdata = {14'd0, rom_span};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_span  <= '0;
      mute_mask <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MUTE) begin
        mute_mask <= pwdata[1:0];
      end else begin
        rom_span <= pwdata[17:0];
      end
    end
  end

  // handshake
  logic cmd_acc;
  assign cmd_stall = (state != S_IDLE) || (res_valid && res_stall);
  assign cmd_acc   = cmd_valid && !cmd_stall;

  // address arithmetic
  logic [LIM_W-1:0]   lim;
  logic [LIM_W-1:0]   a_cur;
  logic [PADDR_W-1:0] pa_inc;
  logic [LIM_W-1:0]   a_new;
  logic [STEP_W-1:0]  inc;
  logic [PHASE_W-1:0] phase_dec;

  assign lim    = ({8'd0, rom_span} < DEPTH_L) ? {8'd0, rom_span} : DEPTH_L;
  assign a_cur  = {1'b0, bank_sel[ch], play_addr[ch][16:0]};
  assign pa_inc = play_addr[ch] + 18'd1;
  assign a_new  = {1'b0, bank_sel[ch], pa_inc[16:0]};
  assign inc    = (step_value[ch] == PHASE_TOP) ? 13'd1 : (PHASE_TOP - step_value[ch]);
  assign phase_dec = phase_count[ch] - PHASE_DEC;

  // sample ROM
  logic          rom_we;
  logic [AW-1:0] rom_waddr;
  logic [7:0]    rom_wdata;
  logic          rom_re;
  logic [AW-1:0] rom_raddr;
  logic [7:0]    rom_rdata;

  always_comb begin
    rom_we    = 1'b0;
    rom_waddr = clr_idx;
    rom_wdata = 8'hFF;
    rom_re    = 1'b0;
    rom_raddr = a_cur[AW-1:0];
    if (state == S_CLR) begin
      rom_we = 1'b1;
    end else if (cmd_acc && cmd.func == FUNC_LOAD && {9'd0, cmd.rom_address} < lim) begin
      rom_we    = 1'b1;
      rom_waddr = AW'({9'd0, cmd.rom_address});
      rom_wdata = cmd.rom_byte;
    end
    if (state == S_CH) begin
      rom_re = 1'b1;
    end else if (state == S_LOOP) begin
      rom_re    = 1'b1;
      rom_raddr = a_new[AW-1:0];
    end
  end

  dcrp_ram #(
    .WIDTH(8),
    .DEPTH(ROM_DEPTH),
    .AW   (AW)
  ) u_rom (
    .clk  (clk),
    .we   (rom_we),
    .waddr(rom_waddr),
    .wdata(rom_wdata),
    .re   (rom_re),
    .raddr(rom_raddr),
    .rdata(rom_rdata)
  );

  // register write decode
  logic       wr_ch;
  logic [3:0] wr_base;
  logic [7:0] lo_next;
  logic [7:0] hi_next;
  logic [7:0] a0_next;
  logic [7:0] a1_next;
  logic [7:0] a2_next;
  logic [3:0] off4;
  logic       port_wr;

  assign wr_ch   = (cmd.reg_offset >= 8'd6);
  assign wr_base = wr_ch ? 4'd6 : 4'd0;
  assign off4    = cmd.reg_offset[3:0];
  assign lo_next = (off4 == wr_base) ? cmd.reg_data : raw_regs[wr_base];
  assign hi_next = (off4 == wr_base + 4'd1) ? cmd.reg_data : raw_regs[wr_base + 4'd1];
  assign a0_next = (off4 == wr_base + 4'd2) ? cmd.reg_data : raw_regs[wr_base + 4'd2];
  assign a1_next = (off4 == wr_base + 4'd3) ? cmd.reg_data : raw_regs[wr_base + 4'd3];
  assign a2_next = (off4 == wr_base + 4'd4) ? cmd.reg_data : raw_regs[wr_base + 4'd4];
  assign port_wr = (cmd.func == FUNC_WRITE) && (cmd.reg_offset == OFF_PORT);

  // mixing product
  logic signed [7:0]  smp;
  logic signed [16:0] prod_l;
  logic signed [16:0] prod_r;
  assign smp    = $signed({1'b0, rom_rdata[6:0]}) - 8'sd64;
  assign prod_l = smp * $signed({1'b0, volume[{ch, 1'b0}]});
  assign prod_r = smp * $signed({1'b0, volume[{ch, 1'b1}]});

  logic skip_ch;
  assign skip_ch = !playing[ch] || mute_mask[ch] || (a_cur >= lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_idx     <= '0;
      ch          <= 1'b0;
      res_valid   <= 1'b0;
      playing     <= '0;
      loop_enable <= '0;
      volume[0]   <= 8'd255;
      volume[1]   <= 8'd0;
      volume[2]   <= 8'd0;
      volume[3]   <= 8'd255;
      for (int i = 0; i < 16; i++) begin
        raw_regs[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        step_value[i]  <= '0;
        start_addr[i]  <= '0;
        play_addr[i]   <= '0;
        phase_count[i] <= PHASE_KEY;
        bank_sel[i]    <= '0;
      end
    end else begin
      if (res_valid && !res_stall && !cmd_acc) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_acc) begin
            res_valid       <= (cmd.func != FUNC_TICK);
            res.left_sum    <= '0;
            res.right_sum   <= '0;
            res.read_data   <= '0;
            res.port_strobe <= port_wr;
            res.port_data   <= port_wr ? cmd.reg_data : 8'd0;
            unique case (cmd.func)
              FUNC_WRITE: begin
                if (cmd.reg_offset < 8'd16) begin
                  raw_regs[off4] <= cmd.reg_data;
                end
                if (cmd.reg_offset <= OFF_KEY1 && (off4 == wr_base || off4 == wr_base + 4'd1)) begin
                  step_value[wr_ch] <= calc_step(lo_next, hi_next);
                end else if (cmd.reg_offset <= OFF_KEY1 && off4 != wr_base + 4'd5) begin
                  start_addr[wr_ch] <= {a2_next[0], a1_next, a0_next};
                end else if (cmd.reg_offset == OFF_KEY0 || cmd.reg_offset == OFF_KEY1) begin
                  playing[wr_ch]     <= 1'b1;
                  play_addr[wr_ch]   <= {1'b0, start_addr[wr_ch]};
                  phase_count[wr_ch] <= PHASE_KEY;
                end else if (cmd.reg_offset == OFF_LOOP) begin
                  loop_enable <= cmd.reg_data;
                end else if (cmd.reg_offset == OFF_VOL0L || cmd.reg_offset == OFF_VOL0R ||
                             cmd.reg_offset == OFF_VOL1L || cmd.reg_offset == OFF_VOL1R) begin
                  volume[cmd.reg_offset[1:0]] <= cmd.reg_data;
                end else if (cmd.reg_offset == OFF_BANK0 || cmd.reg_offset == OFF_BANK1) begin
                  bank_sel[cmd.reg_offset[0]] <= cmd.reg_data;
                end
              end
              FUNC_READ: begin
                if (cmd.reg_offset == OFF_KEY0 || cmd.reg_offset == OFF_KEY1) begin
                  playing[wr_ch]     <= 1'b1;
                  play_addr[wr_ch]   <= {1'b0, start_addr[wr_ch]};
                  phase_count[wr_ch] <= PHASE_KEY;
                end
              end
              FUNC_LOAD: begin
              end
              FUNC_TICK: begin
                ch    <= 1'b0;
                lsum  <= '0;
                rsum  <= '0;
                state <= S_CH;
              end
              default: begin
              end
            endcase
          end
        end
        S_CH: begin
          if (skip_ch) begin
            ch    <= 1'b1;
            state <= ch ? S_FIN : S_CH;
          end else begin
            state <= S_SAMP;
          end
        end
        S_SAMP: begin
          lsum            <= lsum + prod_l;
          rsum            <= rsum + prod_r;
          phase_count[ch] <= phase_dec;
          state           <= S_LOOP;
        end
        S_LOOP: begin
          if (phase_count[ch][PHASE_W-1] && playing[ch]) begin
            phase_count[ch] <= phase_count[ch] + {1'b0, inc};
            play_addr[ch]   <= pa_inc;
            if (a_new >= lim) begin
              playing[ch] <= 1'b0;
              ch          <= 1'b1;
              state       <= ch ? S_FIN : S_CH;
            end else begin
              state <= S_CHK;
            end
          end else begin
            ch    <= 1'b1;
            state <= ch ? S_FIN : S_CH;
          end
        end
        S_CHK: begin
          if (rom_rdata[7] || play_addr[ch][PADDR_W-1]) begin
            if (loop_enable[ch]) begin
              play_addr[ch] <= {1'b0, start_addr[ch]};
            end else begin
              playing[ch] <= 1'b0;
            end
          end
          state <= S_LOOP;
        end
        S_FIN: begin
          res_valid       <= 1'b1;
          res.left_sum    <= lsum[15:0];
          res.right_sum   <= rsum[15:0];
          res.read_data   <= '0;
          res.port_strobe <= 1'b0;
          res.port_data   <= '0;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/dcrp_ram.sv
// ----------------------------------------------------------------------------
// dcrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: dv/dcrp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcrp_checker
// Watches the command, result and configuration ports of the two-channel ROM
// PCM player, predicts every result from its own copy of the player state and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module dcrp_checker
  import dcrp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire logic        cmd_stall,
  input  wire cmd_t        cmd,
  input  wire logic        res_valid,
  input  wire logic        res_stall,
  input  wire res_t        res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fails,
  output int               pending
);

  localparam int unsigned ROM_BYTES = 131072;

  logic [17:0] rom_span;
  logic [1:0]  mute_mask;
  logic [7:0]  raw_regs [16];
  logic [12:0] step_value [2];
  logic [16:0] start_addr [2];
  logic [17:0] play_addr [2];
  int          phase_count [2];
  logic        playing [2];
  logic [7:0]  volume [4];
  logic [7:0]  bank_sel [2];
  logic [7:0]  loop_enable;
  logic [7:0]  rom_mem [ROM_BYTES];
  res_t        mix_expected_q [$];

  initial fails = 0;
  assign pending = mix_expected_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    fails++;
  endtask

  function automatic int unsigned rom_limit();
    return (rom_span < ROM_BYTES) ? int'(rom_span) : ROM_BYTES;
  endfunction

  function automatic int unsigned rom_index(input int c);
    return (int'(bank_sel[c]) << 17) + int'(play_addr[c][16:0]);
  endfunction

  function automatic void key_on(input int c);
    playing[c] = 1'b1;
    play_addr[c] = {1'b0, start_addr[c]};
    phase_count[c] = 4096;
  endfunction

  function automatic void reg_write(input logic [7:0] off, input logic [7:0] d,
                                    inout res_t r);
    int c;
    int b;
    int m;
    logic [7:0] lo;
    logic [7:0] hi;
    c = (off >= 8'h06) ? 1 : 0;
    b = c * 6;
    if (off < 16) raw_regs[off[3:0]] = d;
    m = int'(off) % 6;
    if (off <= OFF_KEY1 && m <= 1) begin
      lo = raw_regs[b];
      hi = raw_regs[b + 1];
      case (hi[5:4])
        2'd1:    step_value[c] = 13'((256 - int'(lo)) << 4);
        2'd2:    step_value[c] = 13'((16 - int'(hi[3:0])) << 8);
        default: step_value[c] = {1'b0, hi[3:0], lo};
      endcase
    end else if (off <= OFF_KEY1 && m <= 4) begin
      start_addr[c] = {raw_regs[b + 4][0], raw_regs[b + 3], raw_regs[b + 2]};
    end else if (off == OFF_KEY0 || off == OFF_KEY1) begin
      key_on(c);
    end else if (off == OFF_PORT) begin
      r.port_strobe = 1'b1;
      r.port_data = d;
    end else if (off == OFF_LOOP) begin
      loop_enable = d;
    end else if (off >= OFF_VOL0L && off <= OFF_VOL1R) begin
      volume[off[1:0]] = d;
    end else if (off == OFF_BANK0 || off == OFF_BANK1) begin
      bank_sel[off[0]] = d;
    end
  endfunction

  function automatic void mix_tick(inout res_t r);
    int lsum;
    int rsum;
    int unsigned lim;
    int unsigned a;
    int s;
    int inc;
    logic [7:0] bt;
    lsum = 0;
    rsum = 0;
    lim = rom_limit();
    for (int c = 0; c < 2; c++) begin
      if (!playing[c] || mute_mask[c]) continue;
      a = rom_index(c);
      if (a >= lim) continue;
      s = int'(rom_mem[a][6:0]) - 64;
      lsum += s * int'(volume[c * 2]);
      rsum += s * int'(volume[c * 2 + 1]);
      inc = 4096 - int'(step_value[c]);
      if (inc <= 0) inc = 1;
      phase_count[c] -= 32;
      while (phase_count[c] < 0 && playing[c]) begin
        phase_count[c] += inc;
        play_addr[c] = play_addr[c] + 18'd1;
        a = rom_index(c);
        if (a >= lim) begin
          playing[c] = 1'b0;
          break;
        end
        bt = rom_mem[a];
        if (bt[7] || play_addr[c][17]) begin
          if (loop_enable[c]) play_addr[c] = {1'b0, start_addr[c]};
          else playing[c] = 1'b0;
        end
      end
    end
    r.left_sum = lsum[15:0];
    r.right_sum = rsum[15:0];
  endfunction

  function automatic res_t predict_transaction(input cmd_t t);
    res_t r;
    r = '0;
    case (t.func)
      FUNC_WRITE: reg_write(t.reg_offset, t.reg_data, r);
      FUNC_READ: begin
        if (t.reg_offset == OFF_KEY0) key_on(0);
        else if (t.reg_offset == OFF_KEY1) key_on(1);
      end
      FUNC_LOAD: begin
        if (t.rom_address < rom_limit()) rom_mem[t.rom_address] = t.rom_byte;
      end
      default: mix_tick(r);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    res_t w;
    if (rst) begin
      rom_span = '0;
      mute_mask = '0;
      loop_enable = '0;
      for (int i = 0; i < 16; i++) raw_regs[i] = '0;
      for (int c = 0; c < 2; c++) begin
        step_value[c] = '0;
        start_addr[c] = '0;
        play_addr[c] = '0;
        phase_count[c] = 4096;
        playing[c] = 1'b0;
        bank_sel[c] = '0;
      end
      volume[0] = 8'd255;
      volume[1] = 8'd0;
      volume[2] = 8'd0;
      volume[3] = 8'd255;
      for (int i = 0; i < ROM_BYTES; i++) rom_mem[i] = 8'hFF;
      mix_expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MUTE) mute_mask = pwdata[1:0];
        else rom_span = pwdata[17:0];
      end
      if (res_valid && !res_stall) begin
        if (mix_expected_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = mix_expected_q.pop_front();
          if (res.left_sum !== w.left_sum)
            report_mismatch("left_sum", res.left_sum, w.left_sum);
          if (res.right_sum !== w.right_sum)
            report_mismatch("right_sum", res.right_sum, w.right_sum);
          if (res.read_data !== w.read_data)
            report_mismatch("read_data", res.read_data, w.read_data);
          if (res.port_strobe !== w.port_strobe)
            report_mismatch("port_strobe", res.port_strobe, w.port_strobe);
          if (res.port_data !== w.port_data)
            report_mismatch("port_data", res.port_data, w.port_data);
        end
      end
      if (cmd_valid && !cmd_stall) mix_expected_q.push_back(predict_transaction(cmd));
    end
  end

endmodule

// File: dv/tb_dual_channel_rom_pcm_player.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_channel_rom_pcm_player
// Drives register, ROM load and tick transactions into the two-channel PCM
// player across several ROM size and mute settings and idle patterns; the
// checker predicts and compares every result, the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_channel_rom_pcm_player;
  import dcrp_pkg::*;

  localparam int ITEMS_PER_PHASE = 380;
  localparam int IDLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fails;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          long_hold_req;
  int unsigned rom_window;
  int          sent;

  dual_channel_rom_pcm_player uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dcrp_checker chk (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side
  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] f, input logic [7:0] off, input logic [7:0] d,
                      input logic [16:0] a, input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    cmd <= '{func: f, reg_offset: off, reg_data: d, rom_address: a, rom_byte: b};
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent++;
  endtask

  task automatic apb_write(input logic reg_index, input logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_index, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_config(input logic [17:0] size, input logic [1:0] mute);
    drain();
    apb_write(REG_ROM_SPAN, {14'd0, size});
    apb_write(REG_MUTE, {30'd0, mute});
    rom_window = size;
  endtask

  task automatic play_sample();
    int ch;
    int len;
    logic [16:0] base;
    logic [7:0] v;
    ch = $urandom_range(1);
    len = $urandom_range(1, 8);
    if (rom_window > 0 && $urandom_range(9) != 0)
      base = (rom_window > 600) ? 17'($urandom_range(rom_window - 1 < 599 ?
             rom_window - 1 : 599)) : 17'($urandom_range(rom_window - 1));
    else
      base = 17'($urandom_range(131071));
    if (base > 131060 && $urandom_range(1)) base = 17'h1FFF0;
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom);
      v[7] = (i == len - 1) ? ($urandom_range(3) != 0) : ($urandom_range(9) == 0);
      send(FUNC_LOAD, 8'($urandom), 8'($urandom), base + 17'(i), v);
    end
    send(FUNC_WRITE, 8'(ch * 6 + 2), base[7:0], 17'($urandom), 8'($urandom));
    send(FUNC_WRITE, 8'(ch * 6 + 3), base[15:8], 17'($urandom), 8'($urandom));
    send(FUNC_WRITE, 8'(ch * 6 + 4), {7'($urandom), base[16]}, 17'($urandom), 8'($urandom));
    send(FUNC_WRITE, 8'(ch * 6), 8'($urandom), 17'($urandom), 8'($urandom));
    v = 8'($urandom);
    if ($urandom_range(1)) v[3:0] = 4'hF;
    send(FUNC_WRITE, 8'(ch * 6 + 1), v, 17'($urandom), 8'($urandom));
    if ($urandom_range(1))
      send(FUNC_WRITE, OFF_LOOP, 8'($urandom), 17'($urandom), 8'($urandom));
    if ($urandom_range(1))
      send(FUNC_WRITE, 8'(OFF_VOL0L + $urandom_range(3)), 8'($urandom), 17'($urandom),
           8'($urandom));
    if ($urandom_range(7) == 0)
      send(FUNC_WRITE, 8'(OFF_BANK0 + ch), 8'($urandom_range(2)), 17'($urandom),
           8'($urandom));
    send($urandom_range(1) ? FUNC_WRITE : FUNC_READ, ch ? OFF_KEY1 : OFF_KEY0,
         8'($urandom), 17'($urandom), 8'($urandom));
    repeat ($urandom_range(2, 12))
      send(FUNC_TICK, 8'($urandom), 8'($urandom), 17'($urandom), 8'($urandom));
  endtask

  task automatic random_items(input int n);
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(9) < 7) play_sample();
      else send(2'($urandom), 8'($urandom), 8'($urandom), 17'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [17:0] sizes [4];
    logic [1:0] mutes [4];
    int pcts_s [4];
    int pcts_r [4];
    sizes = '{18'd131072, 18'd4096, 18'd0, 18'd2048};
    mutes = '{2'd0, 2'd2, 2'd1, 2'd3};
    pcts_s = '{0, 65, 0, 16};
    pcts_r = '{0, 0, 65, 16};
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b0;
    sent = 0;
    rom_window = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_config(18'd131072, 2'd0);

    send(FUNC_LOAD, 8'h00, 8'h00, 17'd0, 8'h40);
    send(FUNC_LOAD, 8'h00, 8'h00, 17'h1FFFF, 8'h00);
    send(FUNC_LOAD, 8'h00, 8'h00, 17'd1, 8'h7F);
    send(FUNC_LOAD, 8'h00, 8'h00, 17'd2, 8'h80);
    send(FUNC_WRITE, 8'h02, 8'h00, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'h00, 8'h00, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'h01, 8'h20, 17'd0, 8'h00);
    send(FUNC_WRITE, OFF_LOOP, 8'h01, 17'd0, 8'h00);
    send(FUNC_WRITE, OFF_KEY0, 8'h00, 17'd0, 8'h00);
    send(FUNC_TICK, 8'h00, 8'h00, 17'd0, 8'h00);
    send(FUNC_TICK, 8'hFF, 8'hFF, 17'h1FFFF, 8'hFF);
    send(FUNC_WRITE, 8'h08, 8'hFF, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'h09, 8'hFF, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'h0A, 8'h01, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'h06, 8'h00, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'h07, 8'h10, 17'd0, 8'h00);
    send(FUNC_READ, OFF_KEY1, 8'h00, 17'd0, 8'h00);
    send(FUNC_TICK, 8'h00, 8'h00, 17'd0, 8'h00);
    send(FUNC_WRITE, OFF_PORT, 8'hA5, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'hFF, 8'h5A, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'h0E, 8'hC3, 17'd0, 8'h00);
    send(FUNC_READ, 8'h00, 8'hFF, 17'd0, 8'h00);
    send(FUNC_WRITE, OFF_VOL1L, 8'hFF, 17'd0, 8'h00);
    send(FUNC_WRITE, OFF_BANK0, 8'h01, 17'd0, 8'h00);
    send(FUNC_TICK, 8'h00, 8'h00, 17'd0, 8'h00);
    send(FUNC_WRITE, OFF_BANK0, 8'h00, 17'd0, 8'h00);
    send(FUNC_WRITE, 8'h01, 8'h3F, 17'd0, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      set_config(sizes[ph], mutes[ph]);
      send_idle_pct = pcts_s[ph];
      recv_stall_pct = pcts_r[ph];
      random_items(ITEMS_PER_PHASE / 2);
      if (ph == 0) long_hold_req = 1'b1;
      random_items(ITEMS_PER_PHASE / 4);
      drain();
      random_items(ITEMS_PER_PHASE / 4);
    end

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
